### hdl/pdrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrb_pkg
// Shared constants, codes and types for the packet reorder buffer.
// ----------------------------------------------------------------------------
package pdrb_pkg;

   localparam int BUFFER_DEPTH_DEF = 32;
   localparam int SEQ_BITS_DEF     = 16;
   localparam int HANDLE_BITS_DEF  = 8;

   localparam int STAMP_W  = 32;
   localparam int STATUS_W = 4;
   localparam int CMD_W    = 2;
   localparam int THRESH_W = 5;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(16);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MARK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_QUEUED    = 4'd0;
   localparam logic [STATUS_W-1:0] ST_DUP       = 4'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 4'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 4'd3;
   localparam logic [STATUS_W-1:0] ST_STALE     = 4'd4;
   localparam logic [STATUS_W-1:0] ST_IN_ORDER  = 4'd5;
   localparam logic [STATUS_W-1:0] ST_GAP       = 4'd6;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd7;
   localparam logic [STATUS_W-1:0] ST_NEW_MARK  = 4'd8;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_CHECK,
      S_REQUEUE,
      S_TAKE
   } state_type;

   // operation on the sorted buffer, at most one per cycle
   typedef struct packed {
      logic insert;
      logic replace;
      logic pop;
   } sort_ctrl_type;

   typedef struct packed {
      logic full;
      logic hit;
   } sort_stat_type;

endpackage

### hdl/pdrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pdrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/pdrb_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrb_sorter
// Row of key/handle cells kept in ascending key order; head is cell 0.
// ----------------------------------------------------------------------------
module pdrb_sorter #(
   parameter int BUFFER_DEPTH = pdrb_pkg::BUFFER_DEPTH_DEF,
   parameter int KEY_W        = 48,
   parameter int HANDLE_BITS  = pdrb_pkg::HANDLE_BITS_DEF,
   localparam int CNT_W       = $clog2(BUFFER_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pdrb_pkg::sort_ctrl_type ctrl,
   input  logic [KEY_W-1:0]        new_key,
   input  logic [HANDLE_BITS-1:0]  new_handle,
   output pdrb_pkg::sort_stat_type stat,
   output logic [HANDLE_BITS-1:0]  hit_handle,
   output logic [KEY_W-1:0]        head_key,
   output logic [HANDLE_BITS-1:0]  head_handle,
   output logic [CNT_W-1:0]        count
);

   logic [KEY_W-1:0]       key_ff    [BUFFER_DEPTH];
   logic [KEY_W-1:0]       key_in    [BUFFER_DEPTH];
   logic [HANDLE_BITS-1:0] handle_ff [BUFFER_DEPTH];
   logic [HANDLE_BITS-1:0] handle_in [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0] lt;
   logic [BUFFER_DEPTH-1:0] eq;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   genvar i;
   generate
      for (i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
         logic valid;
         logic ins_here;
         assign valid = CNT_W'(i) < count_ff;
         assign lt[i] = valid && (key_ff[i] < new_key);
         assign eq[i] = valid && (key_ff[i] == new_key);
         if (i == 0) begin : g_first
            assign ins_here = !lt[0];
         end else begin : g_rest
            assign ins_here = !lt[i] && lt[i-1];
         end

         always_comb begin
            key_in[i]    = key_ff[i];
            handle_in[i] = handle_ff[i];
            if (ctrl.insert && !lt[i]) begin
               if (ins_here) begin
                  key_in[i]    = new_key;
                  handle_in[i] = new_handle;
               end else begin
                  key_in[i]    = key_ff[(i > 0) ? i - 1 : 0];
                  handle_in[i] = handle_ff[(i > 0) ? i - 1 : 0];
               end
            end else if (ctrl.replace && eq[i]) begin
               handle_in[i] = new_handle;
            end else if (ctrl.pop && (i < BUFFER_DEPTH - 1)) begin
               key_in[i]    = key_ff[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
               handle_in[i] = handle_ff[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
            end
         end

         always_ff @(posedge clock) begin
            key_ff[i]    <= key_in[i];
            handle_ff[i] <= handle_in[i];
         end
      end
   endgenerate

   // keys are unique, so at most one cell matches
   always_comb begin
      hit_handle = '0;
      for (int k = 0; k < BUFFER_DEPTH; k++) begin
         if (eq[k]) begin
            hit_handle = hit_handle | handle_ff[k];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.full   = count_ff == CNT_W'(BUFFER_DEPTH);
   assign stat.hit    = |eq;
   assign head_key    = key_ff[0];
   assign head_handle = handle_ff[0];
   assign count       = count_ff;

endmodule

### hdl/packet_dedup_reorder_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_dedup_reorder_buffer
// Reorder buffer with a per-number timestamp duplicate filter.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (insert, take, mark); rsp_* returns one
//   or more result words per command, the final one with rsp_last set.
//   Command 3 is consumed and gives no result.
//   csr_we/csr_wdata write the release threshold at any time the block is idle.
// Timing:
//   insert and mark: table read, then check and, for a new stamp, write back;
//   result word loaded in the check step; next command taken once back in idle,
//   after a second word when an equal key is requeued.
//   take: words loaded one a cycle while the output is free (stale drops, then
//   the delivered word, or an empty word if the last entry left is stale); next
//   command taken once back in idle. A not-ready answer is loaded at acceptance.
// Reset:
//   the stamp table is swept to zero, one entry a cycle, over all 2**SEQ_BITS
//   entries (65536 by default), during which no command is taken.
// Stall:
//   results sit in one output register; while rsp_stall holds it, the block
//   waits and takes no further command.
// ----------------------------------------------------------------------------
module packet_dedup_reorder_buffer #(
   parameter int BUFFER_DEPTH = pdrb_pkg::BUFFER_DEPTH_DEF,
   parameter int SEQ_BITS     = pdrb_pkg::SEQ_BITS_DEF,
   parameter int HANDLE_BITS  = pdrb_pkg::HANDLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pdrb_pkg::CMD_W-1:0]      req_cmd,
   input  logic [SEQ_BITS-1:0]             req_seq_num,
   input  logic [pdrb_pkg::STAMP_W-1:0]    req_stamp,
   input  logic [HANDLE_BITS-1:0]          req_handle,
   input  logic [SEQ_BITS-1:0]             req_expected_num,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pdrb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [HANDLE_BITS-1:0]          rsp_out_handle,
   output logic [SEQ_BITS-1:0]             rsp_out_num,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [pdrb_pkg::THRESH_W-1:0]   csr_wdata
);

   localparam int KEY_W = pdrb_pkg::STAMP_W + SEQ_BITS;
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CMP_W = (CNT_W > pdrb_pkg::THRESH_W) ? CNT_W : pdrb_pkg::THRESH_W;

   pdrb_pkg::state_type state_ff, state_in;

   logic [pdrb_pkg::THRESH_W-1:0] thresh_ff;
   logic [SEQ_BITS-1:0]           clr_ff, clr_in;
   logic [pdrb_pkg::CMD_W-1:0]    cmd_ff;
   logic [SEQ_BITS-1:0]           seq_ff;
   logic [pdrb_pkg::STAMP_W-1:0]  stamp_ff;
   logic [HANDLE_BITS-1:0]        handle_ff;
   logic [SEQ_BITS-1:0]           exp_ff;

   logic                          rv_ff;
   logic [pdrb_pkg::STATUS_W-1:0] rst_ff, rst_in;
   logic [HANDLE_BITS-1:0]        rh_ff, rh_in;
   logic [SEQ_BITS-1:0]           rn_ff, rn_in;
   logic                          rl_ff, rl_in;
   logic                          out_load;
   logic                          out_free;
   logic                          accept;

   logic                          ram_we, ram_re;
   logic [SEQ_BITS-1:0]           ram_waddr;
   logic [pdrb_pkg::STAMP_W-1:0]  ram_wdata, ram_rdata;

   pdrb_pkg::sort_ctrl_type       sctrl;
   pdrb_pkg::sort_stat_type       sstat;
   logic [HANDLE_BITS-1:0]        hit_handle, head_handle;
   logic [KEY_W-1:0]              head_key;
   logic [CNT_W-1:0]              count;
   logic [SEQ_BITS-1:0]           head_num;
   logic                          is_dup;
   logic                          ready;
   logic                          is_stale;

   assign out_free  = !rv_ff || !rsp_stall;
   assign req_stall = !((state_ff == pdrb_pkg::S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign is_dup    = ram_rdata == stamp_ff;
   assign head_num  = head_key[SEQ_BITS-1:0];
   assign ready     = CMP_W'(count) > CMP_W'(thresh_ff);
   assign is_stale  = head_num < exp_ff;

   pdrb_ram #(
      .WIDTH (pdrb_pkg::STAMP_W),
      .DEPTH (2 ** SEQ_BITS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (req_seq_num),
      .rdata (ram_rdata)
   );

   pdrb_sorter #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .KEY_W        (KEY_W),
      .HANDLE_BITS  (HANDLE_BITS)
   ) u_sorter (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sctrl),
      .new_key     ({stamp_ff, seq_ff}),
      .new_handle  (handle_ff),
      .stat        (sstat),
      .hit_handle  (hit_handle),
      .head_key    (head_key),
      .head_handle (head_handle),
      .count       (count)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdrb_pkg::S_CLEAR: begin
            if (clr_ff == {SEQ_BITS{1'b1}}) begin
               state_in = pdrb_pkg::S_IDLE;
            end
         end
         pdrb_pkg::S_IDLE: begin
            if (accept) begin
               if (req_cmd == pdrb_pkg::CMD_INSERT || req_cmd == pdrb_pkg::CMD_MARK) begin
                  state_in = pdrb_pkg::S_LOOKUP;
               end else if (req_cmd == pdrb_pkg::CMD_TAKE && ready) begin
                  state_in = pdrb_pkg::S_TAKE;
               end
            end
         end
         pdrb_pkg::S_LOOKUP: begin
            state_in = pdrb_pkg::S_CHECK;
         end
         pdrb_pkg::S_CHECK: begin
            if (out_free) begin
               if (!is_dup && cmd_ff == pdrb_pkg::CMD_INSERT && sstat.hit) begin
                  state_in = pdrb_pkg::S_REQUEUE;
               end else begin
                  state_in = pdrb_pkg::S_IDLE;
               end
            end
         end
         pdrb_pkg::S_REQUEUE: begin
            if (out_free) begin
               state_in = pdrb_pkg::S_IDLE;
            end
         end
         pdrb_pkg::S_TAKE: begin
            if (out_free && !(is_stale && count != CNT_W'(1))) begin
               state_in = pdrb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pdrb_pkg::S_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = seq_ff;
      ram_wdata = stamp_ff;
      sctrl     = '0;
      out_load  = 1'b0;
      rst_in    = pdrb_pkg::ST_QUEUED;
      rh_in     = handle_ff;
      rn_in     = seq_ff;
      rl_in     = 1'b1;
      clr_in    = clr_ff;
      case (state_ff)
         pdrb_pkg::S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + SEQ_BITS'(1);
         end
         pdrb_pkg::S_IDLE: begin
            ram_re = accept;
            if (accept && req_cmd == pdrb_pkg::CMD_TAKE && !ready) begin
               out_load = 1'b1;
               rst_in   = pdrb_pkg::ST_NOT_READY;
               rh_in    = '0;
               rn_in    = '0;
            end
         end
         pdrb_pkg::S_CHECK: begin
            if (out_free) begin
               out_load = 1'b1;
               if (is_dup) begin
                  rst_in = pdrb_pkg::ST_DUP;
                  if (cmd_ff == pdrb_pkg::CMD_MARK) begin
                     rh_in = '0;
                  end
               end else begin
                  ram_we = 1'b1;
                  if (cmd_ff == pdrb_pkg::CMD_MARK) begin
                     rst_in = pdrb_pkg::ST_NEW_MARK;
                     rh_in  = '0;
                  end else if (sstat.hit) begin
                     // equal key already queued: return the old handle first
                     sctrl.replace = 1'b1;
                     rst_in        = pdrb_pkg::ST_DUP;
                     rh_in         = hit_handle;
                     rl_in         = 1'b0;
                  end else if (sstat.full) begin
                     rst_in = pdrb_pkg::ST_FULL;
                  end else begin
                     sctrl.insert = 1'b1;
                  end
               end
            end
         end
         pdrb_pkg::S_REQUEUE: begin
            out_load = out_free;
         end
         pdrb_pkg::S_TAKE: begin
            if (out_free) begin
               out_load  = 1'b1;
               sctrl.pop = 1'b1;
               rh_in     = head_handle;
               rn_in     = head_num;
               if (is_stale) begin
                  rst_in = (count == CNT_W'(1)) ? pdrb_pkg::ST_EMPTY : pdrb_pkg::ST_STALE;
                  rl_in  = count == CNT_W'(1);
               end else begin
                  rst_in = (head_num == exp_ff) ? pdrb_pkg::ST_IN_ORDER : pdrb_pkg::ST_GAP;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pdrb_pkg::S_CLEAR;
         clr_ff    <= '0;
         thresh_ff <= pdrb_pkg::THRESH_RESET;
         rv_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_we) begin
            thresh_ff <= csr_wdata;
         end
         if (out_load) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         seq_ff    <= req_seq_num;
         stamp_ff  <= req_stamp;
         handle_ff <= req_handle;
         exp_ff    <= req_expected_num;
      end
      if (out_load) begin
         rst_ff <= rst_in;
         rh_ff  <= rh_in;
         rn_ff  <= rn_in;
         rl_ff  <= rl_in;
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rst_ff;
   assign rsp_out_handle = rh_ff;
   assign rsp_out_num    = rn_ff;
   assign rsp_last       = rl_ff;

endmodule
